// ----- rtl/core/scbp_pkg.sv -----
// Shared types and constants for the scan byte to pixel unpacker.
`default_nettype none

package scbp_pkg;

  // Widths of the fixed result fields and configuration ports
  localparam int unsigned PosOutW   = 16;
  localparam int unsigned PixelW    = 24;
  localparam int unsigned MaskW     = 3;
  localparam int unsigned CfgDataW  = 16;
  localparam int unsigned CfgIdxW   = 2;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_FRAME_FORMAT = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_LINE_ART     = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_LINE_WIDTH   = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_LINE_COUNT   = 2'd3;

  // Lane masks
  localparam logic [MaskW-1:0] MASK_FULL  = 3'd7;
  localparam logic [MaskW-1:0] MASK_RED   = 3'd4;
  localparam logic [MaskW-1:0] MASK_GREEN = 3'd2;
  localparam logic [MaskW-1:0] MASK_BLUE  = 3'd1;

  // Frame formats; codes 5 to 7 are unused and drop the byte
  typedef enum logic [2:0] {
    FMT_GRAY  = 3'd0,
    FMT_RGB   = 3'd1,
    FMT_RED   = 3'd2,
    FMT_GREEN = 3'd3,
    FMT_BLUE  = 3'd4
  } fmt_e;

  typedef struct packed {
    fmt_e          frame_format;
    logic          line_art;
    logic [15:0]   line_width;
    logic [15:0]   line_count;
  } cfg_t;

  typedef struct packed {
    logic [PosOutW-1:0] column;
    logic [PosOutW-1:0] row;
    logic [PixelW-1:0]  pixel_value;
    logic [MaskW-1:0]   channel_mask;
    logic               last_of_run;
  } pix_t;

endpackage

`default_nettype wire

// ----- rtl/core/scbp_cfg.sv -----
// Configuration register file of the unpacker.
`default_nettype none

module scbp_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [scbp_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [scbp_pkg::CfgDataW-1:0] cfg_data_i,
  output scbp_pkg::cfg_t                cfg_o
);
  import scbp_pkg::*;

  cfg_t cfg_q;

  // Register writes, one register per beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_format <= FMT_GRAY;
      cfg_q.line_art     <= 1'b0;
      cfg_q.line_width   <= 16'd1;
      cfg_q.line_count   <= 16'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_FRAME_FORMAT: cfg_q.frame_format <= fmt_e'(cfg_data_i[2:0]);
        CFG_LINE_ART:     cfg_q.line_art     <= cfg_data_i[0];
        CFG_LINE_WIDTH:   cfg_q.line_width   <= cfg_data_i[15:0];
        CFG_LINE_COUNT:   cfg_q.line_count   <= cfg_data_i[15:0];
        default:          cfg_q.line_art     <= cfg_q.line_art;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ----- rtl/core/scbp_engine.sv -----
// Input register, raster position, rgb carry and the per-pixel step logic.
`default_nettype none

module scbp_engine #(
  parameter int unsigned COORD_WIDTH = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  scbp_pkg::cfg_t cfg_i,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  logic [7:0]     data_byte_i,
  input  logic           frame_start_i,
  input  logic           adv_i,
  output logic           wr_o,
  output scbp_pkg::pix_t pix_o
);
  import scbp_pkg::*;

  localparam int unsigned XW = ((COORD_WIDTH > 16) ? COORD_WIDTH : 16) + 1;
  localparam logic [COORD_WIDTH-1:0] COORD_MAX = '1;

  // Held byte and its progress through a line-art burst
  logic       item_vld_q;
  logic [7:0] byte_q;
  logic       fs_q;
  logic [2:0] bit_q;

  // Position and rgb carry
  logic [COORD_WIDTH-1:0] col_q, col_d, row_q, row_d;
  logic [7:0]             held0_q, held0_d, held1_q, held1_d;
  logic [1:0]             hcnt_q, hcnt_d;

  logic                   apply_fs, line_art_mode;
  logic [COORD_WIDTH-1:0] col_e, row_e, col_w, row_w, row_wi, row_ei, col_n, row_n;
  logic [7:0]             held0_e, held1_e;
  logic [1:0]             hcnt_e;
  logic [15:0]            eff_width;
  logic [XW-1:0]          col_ex, row_ex, row_wx, row_nx, col_wx, col_out_x, row_out_x;
  logic [XW-1:0]          width_x, count_x;
  logic                   blocked0, blocked1, wrap0, adv_wrap, nxt_blocked;
  logic                   want, wr, last, done, step_go, bitv;
  logic [PixelW-1:0]      val;
  logic [MaskW-1:0]       mask;

  // Frame start clears the state before the first pixel of its byte
  assign apply_fs = fs_q && (bit_q == 3'd0);
  assign col_e    = apply_fs ? '0 : col_q;
  assign row_e    = apply_fs ? '0 : row_q;
  assign held0_e  = apply_fs ? 8'd0 : held0_q;
  assign held1_e  = apply_fs ? 8'd0 : held1_q;
  assign hcnt_e   = apply_fs ? 2'd0 : hcnt_q;

  assign eff_width = (cfg_i.line_width == 16'd0) ? 16'd1 : cfg_i.line_width;
  assign width_x   = XW'(eff_width);
  assign count_x   = XW'(cfg_i.line_count);
  assign col_ex    = XW'(col_e);
  assign row_ex    = XW'(row_e);

  // Wrap before the write, row saturates at the top value
  assign row_ei   = (row_e == COORD_MAX) ? row_e : row_e + 1'b1;
  assign blocked0 = (row_ex >= count_x) || (row_e == COORD_MAX);
  assign wrap0    = col_ex >= width_x;
  assign col_w    = wrap0 ? '0 : col_e;
  assign row_w    = wrap0 ? row_ei : row_e;
  assign row_wx   = XW'(row_w);
  assign col_wx   = XW'(col_w);
  assign blocked1 = (row_wx >= count_x) || (row_w == COORD_MAX);

  // Advance after the write
  assign row_wi   = (row_w == COORD_MAX) ? row_w : row_w + 1'b1;
  assign adv_wrap = (col_w == COORD_MAX) || ((col_wx + 1'b1) >= width_x);

  assign line_art_mode = (cfg_i.frame_format == FMT_GRAY) && cfg_i.line_art;
  assign bitv          = byte_q[3'd7 - bit_q];

  // Pixel value, lanes and rgb carry by format
  always_comb begin
    want    = 1'b0;
    val     = '0;
    mask    = MASK_FULL;
    held0_d = held0_e;
    held1_d = held1_e;
    hcnt_d  = hcnt_e;
    unique case (cfg_i.frame_format)
      FMT_GRAY: begin
        want = 1'b1;
        val  = line_art_mode ? {{(PixelW-1){1'b0}}, ~bitv} : PixelW'(byte_q);
      end
      FMT_RGB: begin
        if (hcnt_e >= 2'd2) begin
          want   = 1'b1;
          val    = {held0_e, held1_e, byte_q};
          hcnt_d = 2'd0;
        end else begin
          if (hcnt_e[0]) begin
            held1_d = byte_q;
          end else begin
            held0_d = byte_q;
          end
          hcnt_d = hcnt_e + 2'd1;
        end
      end
      FMT_RED: begin
        want = 1'b1;
        val  = {byte_q, 16'd0};
        mask = MASK_RED;
      end
      FMT_GREEN: begin
        want = 1'b1;
        val  = {8'd0, byte_q, 8'd0};
        mask = MASK_GREEN;
      end
      FMT_BLUE: begin
        want = 1'b1;
        val  = {16'd0, byte_q};
        mask = MASK_BLUE;
      end
      default: want = 1'b0;
    endcase
  end

  // Next position
  always_comb begin
    col_n = col_e;
    row_n = row_e;
    if (want && !blocked0) begin
      if (blocked1) begin
        col_n = col_w;
        row_n = row_w;
      end else if (adv_wrap) begin
        col_n = '0;
        row_n = row_wi;
      end else begin
        col_n = col_w + 1'b1;
        row_n = row_w;
      end
    end
  end

  // A dropped pixel means every later pixel of the byte drops too
  assign wr          = want && !blocked1;
  assign row_nx      = XW'(row_n);
  assign nxt_blocked = (row_nx >= count_x) || (row_n == COORD_MAX);
  assign last        = !line_art_mode || (bit_q == 3'd7) || nxt_blocked;
  assign done        = !wr || last;

  assign step_go    = item_vld_q && adv_i;
  assign in_stall_o = item_vld_q && !(step_go && done);

  // Input register and bit counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
      bit_q      <= 3'd0;
    end else if (in_valid_i && !in_stall_o) begin
      item_vld_q <= 1'b1;
      bit_q      <= 3'd0;
    end else if (step_go) begin
      if (done) begin
        item_vld_q <= 1'b0;
      end else begin
        bit_q <= bit_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      byte_q <= data_byte_i;
      fs_q   <= frame_start_i;
    end
  end

  // Position and carry registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      held0_q <= 8'd0;
      held1_q <= 8'd0;
      hcnt_q  <= 2'd0;
    end else if (step_go) begin
      col_q   <= col_n;
      row_q   <= row_n;
      held0_q <= held0_d;
      held1_q <= held1_d;
      hcnt_q  <= hcnt_d;
    end
  end

  // Result of this step
  assign col_out_x = col_wx;
  assign row_out_x = row_wx;
  assign wr_o      = step_go && wr;

  always_comb begin
    pix_o.column       = col_out_x[PosOutW-1:0];
    pix_o.row          = row_out_x[PosOutW-1:0];
    pix_o.pixel_value  = val;
    pix_o.channel_mask = mask;
    pix_o.last_of_run  = last;
  end

endmodule

`default_nettype wire

// ----- rtl/core/scbp_outreg.sv -----
// Result register between the step logic and the output channel.
`default_nettype none

module scbp_outreg (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_i,
  input  scbp_pkg::pix_t pix_i,
  output logic           adv_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output scbp_pkg::pix_t pix_o
);
  import scbp_pkg::*;

  logic out_vld_q;
  pix_t pix_q;

  // Room for a new beat when empty or when the held beat leaves now
  assign adv_o = !out_vld_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv_o) begin
      out_vld_q <= wr_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o && wr_i) begin
      pix_q <= pix_i;
    end
  end

  assign out_valid_o = out_vld_q;
  assign pix_o       = pix_q;

endmodule

`default_nettype wire

// ----- rtl/core/scan_byte_to_pixel_unpacker.sv -----
// Top level of the scan byte to pixel unpacker.
//
//   channel | direction | handshake              | beat payload
//   --------+-----------+------------------------+----------------------------------------
//   input   | in        | in_valid_i/in_stall_o  | data_byte_i, frame_start_i
//   output  | out       | out_valid_o/out_stall_i| column_o, row_o, pixel_value_o,
//           |           |                        | channel_mask_o, last_of_run_o
//   config  | in        | cfg_we_i               | cfg_idx_i, cfg_data_i
//
// One byte per cycle in gray, rgb and plane formats while the output does not stall;
// a line-art byte holds the input register until its pixels, up to eight, are written.
// A byte is held in the input register and its result in the result register.
// Reset clears position, rgb carry and configuration to defaults.
// A stalled output holds the result register; the input stalls while the
// input register holds a byte whose last pixel cannot be handed on yet.
`default_nettype none

module scan_byte_to_pixel_unpacker #(
  parameter int unsigned COORD_WIDTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [scbp_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [scbp_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [7:0]                    data_byte_i,
  input  logic                          frame_start_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [15:0]                   column_o,
  output logic [15:0]                   row_o,
  output logic [23:0]                   pixel_value_o,
  output logic [2:0]                    channel_mask_o,
  output logic                          last_of_run_o
);
  import scbp_pkg::*;

  cfg_t cfg;
  pix_t pix_step, pix_out;
  logic wr, adv;

  scbp_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  scbp_engine #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_engine (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .data_byte_i   (data_byte_i),
    .frame_start_i (frame_start_i),
    .adv_i         (adv),
    .wr_o          (wr),
    .pix_o         (pix_step)
  );

  scbp_outreg u_outreg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_i        (wr),
    .pix_i       (pix_step),
    .adv_o       (adv),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .pix_o       (pix_out)
  );

  assign column_o       = pix_out.column;
  assign row_o          = pix_out.row;
  assign pixel_value_o  = pix_out.pixel_value;
  assign channel_mask_o = pix_out.channel_mask;
  assign last_of_run_o  = pix_out.last_of_run;

endmodule

`default_nettype wire

// ----- rtl/core/scbp_chk.sv -----
// Port-level assertions for the unpacker and their bind to the top level.
`default_nettype none

module scbp_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [15:0] column_o,
  input logic [15:0] row_o,
  input logic [23:0] pixel_value_o,
  input logic [2:0]  channel_mask_o,
  input logic        last_of_run_o
);

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(column_o) && $stable(row_o)
      && $stable(pixel_value_o) && $stable(channel_mask_o) && $stable(last_of_run_o))
    else $error("stalled result beat changed");

  // Only full pixels or a single lane
  a_mask: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> channel_mask_o == 3'd7 || channel_mask_o == 3'd4
      || channel_mask_o == 3'd2 || channel_mask_o == 3'd1)
    else $error("bad lane mask");

  // A plane byte gives exactly one write
  a_plane_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && channel_mask_o != 3'd7 |-> last_of_run_o)
    else $error("plane write not last of run");

  // Red plane bytes sit only in their own lane
  a_plane_lane: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && channel_mask_o == 3'd4 |-> pixel_value_o[15:0] == 16'd0)
    else $error("red plane value outside its lane");

endmodule

bind scan_byte_to_pixel_unpacker scbp_chk u_scbp_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .column_o       (column_o),
  .row_o          (row_o),
  .pixel_value_o  (pixel_value_o),
  .channel_mask_o (channel_mask_o),
  .last_of_run_o  (last_of_run_o)
);

`default_nettype wire

// ----- tb/sv/scan_byte_to_pixel_unpacker_tb.sv -----
// Self-checking testbench for the scan byte to pixel unpacker, with a built-in pixel write predictor.
module scan_byte_to_pixel_unpacker_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import scbp_pkg::*;

  localparam int unsigned COORD_MAX    = 65535;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned PRINT_CAP    = 50;
  localparam int unsigned BURST_MAX    = 8;
  localparam logic [2:0]  FMT_UNUSED_LO = 3'd5;
  localparam logic [2:0]  FMT_UNUSED_HI = 3'd7;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_data;
  logic                in_valid;
  logic                in_stall;
  logic [7:0]          data_byte;
  logic                frame_start;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [15:0]         column;
  logic [15:0]         row;
  logic [23:0]         pixel_value;
  logic [2:0]          channel_mask;
  logic                last_of_run;

  scan_byte_to_pixel_unpacker dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .data_byte_i    (data_byte),
    .frame_start_i  (frame_start),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .column_o       (column),
    .row_o          (row),
    .pixel_value_o  (pixel_value),
    .channel_mask_o (channel_mask),
    .last_of_run_o  (last_of_run)
  );

  always #2 clk = ~clk;

  // Shadow configuration and raster state
  logic [2:0]  fmt_reg   = FMT_GRAY;
  logic        art_reg   = 1'b0;
  logic [15:0] width_reg = 16'd1;
  logic [15:0] count_reg = 16'd1;
  int unsigned col_pos   = 0;
  int unsigned row_pos   = 0;
  logic [7:0]  held [2]  = '{8'h00, 8'h00};
  logic [1:0]  held_cnt  = 2'd0;

  pix_t        burst [BURST_MAX];
  int unsigned burst_len;
  pix_t        pixel_writes_due [$];

  int unsigned mismatch_count = 0;
  bit          steady    = 1'b0;
  bit          send_calm = 1'b0;
  bit          out_calm  = 1'b0;
  int unsigned stall_left = 0;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic int unsigned eff_width();
    return (width_reg == 16'd0) ? 1 : int'(width_reg);
  endfunction

  function automatic bit row_blocked();
    return (row_pos >= count_reg) || (row_pos >= COORD_MAX);
  endfunction

  function automatic void advance_row();
    col_pos = 0;
    if (row_pos < COORD_MAX) row_pos++;
  endfunction

  // One pixel write at the current position; a dropped write keeps only a pending line wrap
  function automatic void emit_pixel(logic [23:0] value, logic [2:0] mask);
    if (burst_len >= BURST_MAX || row_blocked()) return;
    if (col_pos >= eff_width()) advance_row();
    if (row_blocked()) return;
    burst[burst_len].column       = col_pos[15:0];
    burst[burst_len].row          = row_pos[15:0];
    burst[burst_len].pixel_value  = value;
    burst[burst_len].channel_mask = mask;
    burst[burst_len].last_of_run  = 1'b0;
    burst_len++;
    if (col_pos >= COORD_MAX || col_pos + 1 >= eff_width()) advance_row();
    else col_pos++;
  endfunction

  function automatic void predict_pixel_writes(logic [7:0] b, logic start);
    burst_len = 0;
    if (start) begin
      col_pos  = 0;
      row_pos  = 0;
      held[0]  = 8'h00;
      held[1]  = 8'h00;
      held_cnt = 2'd0;
    end
    case (fmt_reg)
      FMT_GRAY: begin
        if (art_reg) begin
          // MSB first, set bit is black (index 0)
          for (int i = 0; i < 8; i++) emit_pixel(b[7-i] ? 24'd0 : 24'd1, MASK_FULL);
        end else begin
          emit_pixel({16'h0000, b}, MASK_FULL);
        end
      end
      FMT_RGB: begin
        if (held_cnt >= 2'd2) begin
          held_cnt = 2'd0;
          emit_pixel({held[0], held[1], b}, MASK_FULL);
        end else begin
          held[held_cnt[0]] = b;
          held_cnt++;
        end
      end
      FMT_RED:   emit_pixel({b, 16'h0000}, MASK_RED);
      FMT_GREEN: emit_pixel({8'h00, b, 8'h00}, MASK_GREEN);
      FMT_BLUE:  emit_pixel({16'h0000, b}, MASK_BLUE);
      default: ;
    endcase
    if (burst_len != 0) burst[burst_len-1].last_of_run = 1'b1;
    for (int i = 0; i < burst_len; i++) pixel_writes_due.push_back(burst[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    mismatch_count++;
    if (mismatch_count <= PRINT_CAP)
      $display("%0t ns: mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
  endtask

  always @(posedge clk) begin
    pix_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pixel_writes_due.size() == 0) begin
        report_mismatch("write with nothing due (column)", column, 0);
      end else begin
        want = pixel_writes_due.pop_front();
        if (column !== want.column) report_mismatch("column", column, want.column);
        if (row !== want.row) report_mismatch("row", row, want.row);
        if (pixel_value !== want.pixel_value)
          report_mismatch("pixel_value", pixel_value, want.pixel_value);
        if (channel_mask !== want.channel_mask)
          report_mismatch("channel_mask", channel_mask, want.channel_mask);
        if (last_of_run !== want.last_of_run)
          report_mismatch("last_of_run", last_of_run, want.last_of_run);
      end
    end
  end

  // Output stall bursts, with calm stretches; none in steady mode
  always @(negedge clk) begin
    if (steady) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else if (stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
      if ($urandom_range(0, 63) == 0) out_calm = !out_calm;
      if (!out_calm && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 17);
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers; every task starts and ends just after a falling edge
  // ---------------------------------------------------------------------------
  task automatic send_byte(logic [7:0] value, logic start);
    int unsigned gap;
    if (!steady) begin
      if ($urandom_range(0, 39) == 0) send_calm = !send_calm;
      if (!send_calm && $urandom_range(0, 4) == 0) begin
        gap = $urandom_range(1, 17);
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    in_valid    <= 1'b1;
    data_byte   <= value;
    frame_start <= start;
    do @(posedge clk); while (in_stall);
    predict_pixel_writes(value, start);
    @(negedge clk);
  endtask

  // Hold off input until every due write has come out, then let the block go quiet
  task automatic settle_outputs();
    in_valid <= 1'b0;
    while (pixel_writes_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] value, bit last_write);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value;
    @(negedge clk);
    if (last_write) cfg_we <= 1'b0;
    case (idx)
      CFG_FRAME_FORMAT: fmt_reg   = value[2:0];
      CFG_LINE_ART:     art_reg   = value[0];
      CFG_LINE_WIDTH:   width_reg = value;
      CFG_LINE_COUNT:   count_reg = value;
      default: ;
    endcase
  endtask

  // Write all four registers; scramble fills the unused upper data bits
  task automatic program_frame(logic [2:0] fmt, logic art, logic [15:0] width,
                               logic [15:0] count, bit scramble = 1'b0);
    logic [CfgDataW-1:0] fmt_word;
    logic [CfgDataW-1:0] art_word;
    settle_outputs();
    fmt_word      = scramble ? 16'($urandom) : '0;
    fmt_word[2:0] = fmt;
    art_word      = scramble ? 16'($urandom) : '0;
    art_word[0]   = art;
    write_reg(CFG_FRAME_FORMAT, fmt_word, 1'b0);
    write_reg(CFG_LINE_ART, art_word, 1'b0);
    write_reg(CFG_LINE_WIDTH, width, 1'b0);
    write_reg(CFG_LINE_COUNT, count, 1'b1);
  endtask

  // Single register change, position and carry untouched
  task automatic set_register(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] value);
    settle_outputs();
    write_reg(idx, value, 1'b1);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_reset_defaults();
    // Default 1x1 gray frame: second byte falls past the last row
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
  endtask

  task automatic test_gray_levels();
    program_frame(FMT_GRAY, 1'b0, 16'd3, 16'd1);
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'h01, 1'b0);
  endtask

  task automatic test_line_art();
    // 15 pixels of room: second byte is cut short, third gives nothing
    program_frame(FMT_GRAY, 1'b1, 16'd5, 16'd3);
    send_byte(8'h80, 1'b1);
    send_byte(8'h7F, 1'b0);
    send_byte(8'hA5, 1'b0);
  endtask

  task automatic test_zero_sizes();
    // Zero width acts as one; zero line count drops every write
    program_frame(FMT_GRAY, 1'b1, 16'd0, 16'd4);
    send_byte(8'hC3, 1'b1);
    program_frame(FMT_GRAY, 1'b0, 16'd7, 16'd0);
    send_byte(8'h5A, 1'b1);
  endtask

  task automatic test_rgb_carry();
    // line_art is ignored outside gray; frame start mid-triplet drops the carry
    program_frame(FMT_RGB, 1'b1, 16'd2, 16'd2);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h12, 1'b0);
    send_byte(8'h34, 1'b0);
    send_byte(8'hAB, 1'b1);
    send_byte(8'hCD, 1'b0);
    send_byte(8'hEF, 1'b0);
  endtask

  task automatic test_single_planes();
    program_frame(FMT_RED, 1'b0, 16'd4, 16'd2);
    send_byte(8'hFF, 1'b1);
    set_register(CFG_FRAME_FORMAT, 16'(FMT_GREEN));
    send_byte(8'h01, 1'b0);
    set_register(CFG_FRAME_FORMAT, 16'(FMT_BLUE));
    send_byte(8'h80, 1'b0);
  endtask

  task automatic test_format_switch();
    // RGB carry survives an unused format and a gray pixel in between
    program_frame(FMT_RGB, 1'b0, 16'd3, 16'd3);
    send_byte(8'h11, 1'b1);
    send_byte(8'h22, 1'b0);
    set_register(CFG_FRAME_FORMAT, 16'(FMT_UNUSED_LO + 3'd1));
    send_byte(8'h33, 1'b0);
    set_register(CFG_FRAME_FORMAT, 16'(FMT_GRAY));
    send_byte(8'h44, 1'b0);
    set_register(CFG_FRAME_FORMAT, 16'(FMT_RGB));
    send_byte(8'h55, 1'b0);
  endtask

  function automatic logic [15:0] pick_size();
    int unsigned r;
    r = $urandom_range(0, 15);
    case (r)
      0:       return 16'd0;
      1:       return 16'hFFFF;
      2:       return 16'($urandom);
      3:       return 16'($urandom_range(1, 300));
      default: return 16'($urandom_range(1, 9));
    endcase
  endfunction

  task automatic test_random_frames();
    int unsigned pick;
    logic [2:0]  fmt;
    logic [15:0] width;
    logic [15:0] count;
    logic        start;
    for (int phase = 0; phase < 11; phase++) begin
      pick = $urandom_range(0, 9);
      case (pick)
        0, 1, 2: fmt = FMT_GRAY;
        3, 4, 5: fmt = FMT_RGB;
        6:       fmt = FMT_RED;
        7:       fmt = FMT_GREEN;
        8:       fmt = FMT_BLUE;
        default: fmt = 3'($urandom_range(FMT_UNUSED_LO, FMT_UNUSED_HI));
      endcase
      width = pick_size();
      count = pick_size();
      if (phase == 0) begin
        width = 16'hFFFF;
        count = 16'hFFFF;
      end else if (phase == 1) begin
        width = 16'd1;
        count = 16'hFFFF;
      end
      program_frame(fmt, 1'($urandom_range(0, 1)), width, count, 1'b1);
      for (int k = 0; k < 17; k++) begin
        // Mid-frame pause until the output side has caught up
        if (phase % 3 == 1 && k == 12) settle_outputs();
        if (k == 0) start = ($urandom_range(0, 3) != 0);
        else start = ($urandom_range(0, 11) == 0);
        send_byte(8'($urandom_range(0, 255)), start);
      end
    end
  endtask

  task automatic test_steady_stream();
    steady = 1'b1;
    program_frame(FMT_GRAY, 1'b1, 16'd13, 16'd9);
    for (int k = 0; k < 20; k++) send_byte(8'($urandom_range(0, 255)), k == 0);
    program_frame(FMT_RGB, 1'b0, 16'd7, 16'd5);
    for (int k = 0; k < 24; k++) send_byte(8'($urandom_range(0, 255)), k == 0);
  endtask

  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    data_byte   = 8'h00;
    frame_start = 1'b0;
    cfg_we      = 1'b0;
    cfg_idx     = CFG_FRAME_FORMAT;
    cfg_data    = '0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_reset_defaults();
    test_gray_levels();
    test_line_art();
    test_zero_sizes();
    test_rgb_carry();
    test_single_planes();
    test_format_switch();
    test_random_frames();
    test_steady_stream();

    settle_outputs();
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Run limit, far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
